[src/lsac_pkg.sv]
// Shared types, constants and the arctangent table of the laser servo aim controller.
`timescale 1ns / 1ps

package lsac_pkg;

  localparam int unsigned COORD_W    = 14;
  localparam int unsigned DIFF_W     = 15;
  localparam int unsigned ANGLE_W    = 15;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned PW_W       = 11;
  localparam int unsigned ALPHA_W    = 14;
  localparam int unsigned SQ_W       = 29;
  localparam int unsigned MUL_W      = 24;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned CORDIC_W   = 34;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned CORDIC_STEPS = 13;
  localparam int unsigned PRESCALE   = 16;

  localparam logic [PW_W-1:0] PW_MIN = 11'd1000;
  localparam logic [PW_W-1:0] PW_MID = 11'd1500;
  localparam logic [PW_W-1:0] PW_MAX = 11'd2000;

  localparam logic signed [ANGLE_W-1:0] PI_UNITS   = 15'sd8192;
  localparam logic signed [ANGLE_W-1:0] HALF_PI    = 15'sd4096;

  // floor(n / 1000) == (n * RECIP_1000) >> RECIP_SHIFT for every n below 2^23
  localparam logic [MUL_W-1:0] RECIP_1000  = 24'd8589935;
  localparam int unsigned      RECIP_SHIFT = 33;
  localparam logic [MUL_W-1:0] DELTA_GAIN  = 24'd1000;
  localparam logic [22:0]      ROUND_HALF  = 23'd500;
  localparam int unsigned      PI_SHIFT    = 13;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } cordic_req_t;

  function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] val;
    unique case (idx)
      4'd0:    val = 15'sd2048;
      4'd1:    val = 15'sd1209;
      4'd2:    val = 15'sd639;
      4'd3:    val = 15'sd324;
      4'd4:    val = 15'sd163;
      4'd5:    val = 15'sd81;
      4'd6:    val = 15'sd41;
      4'd7:    val = 15'sd20;
      4'd8:    val = 15'sd10;
      4'd9:    val = 15'sd5;
      4'd10:   val = 15'sd3;
      4'd11:   val = 15'sd1;
      4'd12:   val = 15'sd1;
      default: val = 15'sd0;
    endcase
    return val;
  endfunction

endpackage

[src/laser_servo_aim_controller.sv]
// Top level of the laser servo aim controller: sequencer, state and result register.
//
//  channel | signals                     | payload
//  --------+-----------------------------+----------------------------------------------
//  in      | in_valid, in_ready          | laser_x/y, heading, front_x/y, rear_x/y
//  out     | out_valid, out_ready        | new_pulse_width, aim_error, servo_angle,
//          |                             | aimed_at_rear
//
// Each item makes six passes through the shared multiplier (S_MUL then S_ACC), runs the
// CORDIC (13 iterations) and steps through S_ANGLE, S_WAIT, S_ERR and S_OUT; a vector with
// a zero component skips the CORDIC iterations.
// Reset returns the pulse width to 1500 and empties the result register.
// A result waits in its register while the next item is taken; the sequencer only holds
// at its final step when the register is still full.
`timescale 1ns / 1ps

module laser_servo_aim_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lsac_pkg::COORD_W-1:0]         laser_x,
  input  logic [lsac_pkg::COORD_W-1:0]         laser_y,
  input  logic signed [lsac_pkg::ANGLE_W-1:0]  heading,
  input  logic [lsac_pkg::COORD_W-1:0]         front_x,
  input  logic [lsac_pkg::COORD_W-1:0]         front_y,
  input  logic [lsac_pkg::COORD_W-1:0]         rear_x,
  input  logic [lsac_pkg::COORD_W-1:0]         rear_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lsac_pkg::PW_W-1:0]            new_pulse_width,
  output logic signed [lsac_pkg::ERR_W-1:0]    aim_error,
  output logic [lsac_pkg::ALPHA_W-1:0]         servo_angle,
  output logic                                 aimed_at_rear
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_ANGLE, S_WAIT, S_ERR, S_OUT} state_t;
  typedef enum logic [2:0] {OP_ALPHA, OP_FX, OP_FY, OP_RX, OP_RY, OP_ERR} op_t;

  state_t                                  state;
  op_t                                     op;

  logic [lsac_pkg::PW_W-1:0]               pulse_width;
  logic [lsac_pkg::COORD_W-1:0]            lx, ly, fx, fy, rx, ry;
  logic signed [lsac_pkg::ANGLE_W-1:0]     head;
  logic [lsac_pkg::ALPHA_W-1:0]            alpha;
  logic [lsac_pkg::SQ_W-1:0]               sq_front, sq_rear;
  logic                                    rear;
  logic signed [lsac_pkg::ANGLE_W-1:0]     gamma;
  logic signed [lsac_pkg::ERR_W-1:0]       err;
  logic [lsac_pkg::PW_W-1:0]               npw;

  logic signed [lsac_pkg::DIFF_W-1:0]      fdx, fdy, rdx, rdy;
  logic [lsac_pkg::DIFF_W-1:0]             mag;
  logic [lsac_pkg::ERR_W-1:0]              err_mag;
  logic [9:0]                              pw_off;
  logic [22:0]                             alpha_num;
  logic signed [lsac_pkg::ERR_W:0]         err_next;
  logic [11:0]                             delta_mag;
  logic signed [13:0]                      npw_sum;
  logic [lsac_pkg::PW_W-1:0]               npw_next;

  lsac_pkg::mul_req_t                      mreq;
  logic [lsac_pkg::PROD_W-1:0]             prod;
  lsac_pkg::cordic_req_t                   creq;
  logic                                    cor_done;
  logic signed [lsac_pkg::ANGLE_W-1:0]     cor_bearing;

  assign fdx = $signed({1'b0, fx}) - $signed({1'b0, lx});
  assign fdy = $signed({1'b0, fy}) - $signed({1'b0, ly});
  assign rdx = $signed({1'b0, rx}) - $signed({1'b0, lx});
  assign rdy = $signed({1'b0, ry}) - $signed({1'b0, ly});

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (op)
      OP_FX:   mag = fdx[lsac_pkg::DIFF_W-1] ? -fdx : fdx;
      OP_FY:   mag = fdy[lsac_pkg::DIFF_W-1] ? -fdy : fdy;
      OP_RX:   mag = rdx[lsac_pkg::DIFF_W-1] ? -rdx : rdx;
      OP_RY:   mag = rdy[lsac_pkg::DIFF_W-1] ? -rdy : rdy;
      default: mag = '0;
    endcase
  end

  assign err_mag   = err[lsac_pkg::ERR_W-1] ? -err : err;
  assign pw_off    = 10'(pulse_width - lsac_pkg::PW_MIN);
  assign alpha_num = {pw_off, 13'd0} + lsac_pkg::ROUND_HALF;

  always_comb begin
    unique case (op)
      OP_ALPHA: begin
        mreq.a = {1'b0, alpha_num};
        mreq.b = lsac_pkg::RECIP_1000;
      end
      OP_ERR: begin
        mreq.a = {8'd0, err_mag};
        mreq.b = lsac_pkg::DELTA_GAIN;
      end
      default: begin
        mreq.a = {9'd0, mag};
        mreq.b = {9'd0, mag};
      end
    endcase
  end

  assign creq.start = (state == S_ANGLE);
  assign creq.dx    = rear ? rdx : fdx;
  assign creq.dy    = rear ? rdy : fdy;

  assign err_next = (lsac_pkg::ERR_W+1)'(signed'(lsac_pkg::HALF_PI))
                  - $signed({3'b0, alpha})
                  + (lsac_pkg::ERR_W+1)'(gamma)
                  - (lsac_pkg::ERR_W+1)'(head);

  assign delta_mag = prod[lsac_pkg::PI_SHIFT+11:lsac_pkg::PI_SHIFT];
  assign npw_sum   = err[lsac_pkg::ERR_W-1]
                   ? $signed({3'b0, pulse_width}) - $signed({2'b0, delta_mag})
                   : $signed({3'b0, pulse_width}) + $signed({2'b0, delta_mag});

  always_comb begin
    if (npw_sum > $signed({3'b0, lsac_pkg::PW_MAX}) ||
        npw_sum < $signed({3'b0, lsac_pkg::PW_MIN})) begin
      npw_next = lsac_pkg::PW_MID;
    end else begin
      npw_next = npw_sum[lsac_pkg::PW_W-1:0];
    end
  end

  lsac_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  lsac_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (creq),
    .done    (cor_done),
    .bearing (cor_bearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_ALPHA;
      out_valid   <= 1'b0;
      pulse_width <= lsac_pkg::PW_MID;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            lx    <= laser_x;
            ly    <= laser_y;
            head  <= heading;
            fx    <= front_x;
            fy    <= front_y;
            rx    <= rear_x;
            ry    <= rear_y;
            op    <= OP_ALPHA;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          unique case (op)
            OP_ALPHA: begin
              alpha <= prod[lsac_pkg::RECIP_SHIFT+lsac_pkg::ALPHA_W-1:lsac_pkg::RECIP_SHIFT];
              op    <= OP_FX;
              state <= S_MUL;
            end
            OP_FX: begin
              sq_front <= prod[lsac_pkg::SQ_W-1:0];
              op       <= OP_FY;
              state    <= S_MUL;
            end
            OP_FY: begin
              sq_front <= sq_front + prod[lsac_pkg::SQ_W-1:0];
              op       <= OP_RX;
              state    <= S_MUL;
            end
            OP_RX: begin
              sq_rear <= prod[lsac_pkg::SQ_W-1:0];
              op      <= OP_RY;
              state   <= S_MUL;
            end
            OP_RY: begin
              rear  <= sq_front > (sq_rear + prod[lsac_pkg::SQ_W-1:0]);
              state <= S_ANGLE;
            end
            OP_ERR: begin
              npw   <= npw_next;
              state <= S_OUT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_ANGLE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (cor_done) begin
            gamma <= cor_bearing;
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err   <= err_next[lsac_pkg::ERR_W-1:0];
          op    <= OP_ERR;
          state <= S_MUL;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            new_pulse_width <= npw;
            aim_error       <= err;
            servo_angle     <= alpha;
            aimed_at_rear   <= rear;
            pulse_width     <= npw;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pw_range: assert property (@(posedge clk) disable iff (rst)
    pulse_width >= lsac_pkg::PW_MIN && pulse_width <= lsac_pkg::PW_MAX)
    else $error("kept pulse width left its range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (new_pulse_width >= lsac_pkg::PW_MIN &&
                   new_pulse_width <= lsac_pkg::PW_MAX && servo_angle <= 14'd8192))
    else $error("result fields out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while an item is in progress");

  a_result_updates_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> (out_valid && pulse_width == new_pulse_width))
    else $error("result register and kept pulse width disagree");

endmodule

[src/lsac_mul.sv]
// Shared registered unsigned multiplier.
`timescale 1ns / 1ps

module lsac_mul (
  input  logic                             clk,
  input  lsac_pkg::mul_req_t               req,
  output logic [lsac_pkg::PROD_W-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end

endmodule

[src/lsac_cordic.sv]
// Iterative vectoring CORDIC that returns the bearing of a difference vector.
`timescale 1ns / 1ps

module lsac_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lsac_pkg::cordic_req_t                 req,
  output logic                                  done,
  output logic signed [lsac_pkg::ANGLE_W-1:0]   bearing
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t                                   state;
  logic signed [lsac_pkg::CORDIC_W-1:0]      x;
  logic signed [lsac_pkg::CORDIC_W-1:0]      y;
  logic signed [lsac_pkg::ANGLE_W-1:0]       z;
  logic [lsac_pkg::STEP_W-1:0]               step;
  logic signed [lsac_pkg::CORDIC_W-1:0]      xs;
  logic signed [lsac_pkg::CORDIC_W-1:0]      ys;
  logic signed [lsac_pkg::CORDIC_W-1:0]      x0;
  logic signed [lsac_pkg::CORDIC_W-1:0]      y0;
  logic signed [lsac_pkg::ANGLE_W-1:0]       tab;

  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign tab = lsac_pkg::atan_entry(step);
  assign x0  = {{3{req.dx[lsac_pkg::DIFF_W-1]}}, req.dx, {lsac_pkg::PRESCALE{1'b0}}};
  assign y0  = {{3{req.dy[lsac_pkg::DIFF_W-1]}}, req.dy, {lsac_pkg::PRESCALE{1'b0}}};

  assign done = (state == C_DONE);

  always_comb begin
    if (z > lsac_pkg::PI_UNITS) begin
      bearing = lsac_pkg::PI_UNITS;
    end else if (z < -lsac_pkg::PI_UNITS) begin
      bearing = -lsac_pkg::PI_UNITS;
    end else begin
      bearing = z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            step <= '0;
            if (req.dx == '0 && req.dy == '0) begin
              z     <= '0;
              state <= C_DONE;
            end else if (req.dy == '0) begin
              z     <= req.dx[lsac_pkg::DIFF_W-1] ? lsac_pkg::PI_UNITS : '0;
              state <= C_DONE;
            end else if (req.dx == '0) begin
              z     <= req.dy[lsac_pkg::DIFF_W-1] ? -lsac_pkg::HALF_PI : lsac_pkg::HALF_PI;
              state <= C_DONE;
            end else if (req.dx[lsac_pkg::DIFF_W-1]) begin
              x     <= -x0;
              y     <= -y0;
              z     <= req.dy[lsac_pkg::DIFF_W-1] ? -lsac_pkg::PI_UNITS : lsac_pkg::PI_UNITS;
              state <= C_RUN;
            end else begin
              x     <= x0;
              y     <= y0;
              z     <= '0;
              state <= C_RUN;
            end
          end
        end
        C_RUN: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + tab;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - tab;
          end
          step <= step + 1'b1;
          if (step == lsac_pkg::STEP_W'(lsac_pkg::CORDIC_STEPS - 1)) begin
            state <= C_DONE;
          end
        end
        C_DONE: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the laser servo aim controller: table, random frames, stalls.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [lsac_pkg::COORD_W-1:0]        lx;
    logic [lsac_pkg::COORD_W-1:0]        ly;
    logic signed [lsac_pkg::ANGLE_W-1:0] hd;
    logic [lsac_pkg::COORD_W-1:0]        fx;
    logic [lsac_pkg::COORD_W-1:0]        fy;
    logic [lsac_pkg::COORD_W-1:0]        rx;
    logic [lsac_pkg::COORD_W-1:0]        ry;
  } aim_frame_t;

  typedef struct packed {
    logic [lsac_pkg::PW_W-1:0]         pw;
    logic signed [lsac_pkg::ERR_W-1:0] err;
    logic [lsac_pkg::ALPHA_W-1:0]      ang;
    logic                              rear;
  } aim_result_t;

  typedef struct {
    aim_frame_t  frame;
    bit          typed;
    aim_result_t want;
  } aim_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [lsac_pkg::COORD_W-1:0]         laser_x = '0;
  logic [lsac_pkg::COORD_W-1:0]         laser_y = '0;
  logic signed [lsac_pkg::ANGLE_W-1:0]  heading = '0;
  logic [lsac_pkg::COORD_W-1:0]         front_x = '0;
  logic [lsac_pkg::COORD_W-1:0]         front_y = '0;
  logic [lsac_pkg::COORD_W-1:0]         rear_x = '0;
  logic [lsac_pkg::COORD_W-1:0]         rear_y = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [lsac_pkg::PW_W-1:0]            new_pulse_width;
  logic signed [lsac_pkg::ERR_W-1:0]    aim_error;
  logic [lsac_pkg::ALPHA_W-1:0]         servo_angle;
  logic                                 aimed_at_rear;

  aim_result_t pending_aims[$];
  aim_row_t    aim_table[$];
  int          model_pw = 1500;
  int          tx_idle_pct = 16;
  int          rx_idle_pct = 86;
  logic        rx_hold = 1'b0;
  int          mismatches = 0;
  int          frames_sent = 0;
  int          results_seen = 0;
  int          rear_picks = 0;
  int          pw_recenters = 0;

  laser_servo_aim_controller u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .laser_x         (laser_x),
    .laser_y         (laser_y),
    .heading         (heading),
    .front_x         (front_x),
    .front_y         (front_y),
    .rear_x          (rear_x),
    .rear_y          (rear_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .new_pulse_width (new_pulse_width),
    .aim_error       (aim_error),
    .servo_angle     (servo_angle),
    .aimed_at_rear   (aimed_at_rear)
  );

  always #4 clk = ~clk;

  function automatic int cordic_bearing(input int dx, input int dy);
    longint x;
    longint y;
    longint xn;
    longint yn;
    int     z;
    int     steps [lsac_pkg::CORDIC_STEPS] =
              '{2048, 1209, 639, 324, 163, 81, 41, 20, 10, 5, 3, 1, 1};
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dy == 0) return (dx > 0) ? 0 : 8192;
    if (dx == 0) return (dy > 0) ? 4096 : -4096;
    x = longint'(dx) * 65536;
    y = longint'(dy) * 65536;
    if (dx < 0) begin
      x = -x;
      y = -y;
      z = (dy > 0) ? 8192 : -8192;
    end
    for (int i = 0; i < lsac_pkg::CORDIC_STEPS; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z  = z + steps[i];
      end else begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z  = z - steps[i];
      end
      x = xn;
      y = yn;
    end
    if (z > 8192) z = 8192;
    if (z < -8192) z = -8192;
    return z;
  endfunction

  function automatic aim_result_t predict_aim(input aim_frame_t f);
    aim_result_t r;
    int          lx;
    int          ly;
    int          head;
    int          pw;
    int          alpha;
    int          gam;
    int          err;
    int          delta;
    int          npw;
    longint      d_front;
    longint      d_rear;
    bit          rear;
    lx   = int'(f.lx);
    ly   = int'(f.ly);
    head = $signed(f.hd);
    pw   = model_pw;
    if (pw < 1000 || pw > 2000) pw = 1500;
    alpha   = ((pw - 1000) * 8192 + 500) / 1000;
    d_front = longint'(int'(f.fx) - lx) ** 2 + longint'(int'(f.fy) - ly) ** 2;
    d_rear  = longint'(int'(f.rx) - lx) ** 2 + longint'(int'(f.ry) - ly) ** 2;
    rear    = d_front > d_rear;
    if (rear) gam = cordic_bearing(int'(f.rx) - lx, int'(f.ry) - ly);
    else gam = cordic_bearing(int'(f.fx) - lx, int'(f.fy) - ly);
    err   = 4096 - alpha + gam - head;
    delta = (err * 1000) / 8192;
    npw   = pw + delta;
    if (npw > 2000 || npw < 1000) begin
      npw = 1500;
      pw_recenters++;
    end
    if (rear) rear_picks++;
    model_pw = npw;
    r.pw   = npw[lsac_pkg::PW_W-1:0];
    r.err  = err[lsac_pkg::ERR_W-1:0];
    r.ang  = alpha[lsac_pkg::ALPHA_W-1:0];
    r.rear = rear;
    return r;
  endfunction

  function automatic aim_frame_t mk_frame(input int lx, input int ly, input int hd,
                                          input int fx, input int fy,
                                          input int rx, input int ry);
    aim_frame_t f;
    f.lx = lx[lsac_pkg::COORD_W-1:0];
    f.ly = ly[lsac_pkg::COORD_W-1:0];
    f.hd = hd[lsac_pkg::ANGLE_W-1:0];
    f.fx = fx[lsac_pkg::COORD_W-1:0];
    f.fy = fy[lsac_pkg::COORD_W-1:0];
    f.rx = rx[lsac_pkg::COORD_W-1:0];
    f.ry = ry[lsac_pkg::COORD_W-1:0];
    return f;
  endfunction

  function automatic aim_result_t mk_result(input int pw, input int err, input int ang,
                                            input int rear);
    aim_result_t r;
    r.pw   = pw[lsac_pkg::PW_W-1:0];
    r.err  = err[lsac_pkg::ERR_W-1:0];
    r.ang  = ang[lsac_pkg::ALPHA_W-1:0];
    r.rear = rear[0];
    return r;
  endfunction

  task automatic add_row(input aim_frame_t f, input bit typed, input aim_result_t want);
    aim_row_t row;
    row.frame = f;
    row.typed = typed;
    row.want  = want;
    aim_table.insert(aim_table.size(), row);
  endtask

  function automatic aim_frame_t random_frame();
    aim_frame_t f;
    int         mode;
    int         hd;
    int         lx;
    int         ly;
    int         a;
    int         b;
    mode = $urandom_range(9);
    if ($urandom_range(4) == 0) hd = int'($urandom_range(32767)) - 16384;
    else hd = int'($urandom_range(16384)) - 8192;
    f = mk_frame($urandom_range(16383), $urandom_range(16383), hd,
                 $urandom_range(16383), $urandom_range(16383),
                 $urandom_range(16383), $urandom_range(16383));
    case (mode)
      5, 6: begin
        lx = $urandom_range(64, 16319);
        ly = $urandom_range(64, 16319);
        f = mk_frame(lx, ly, hd,
                     lx + int'($urandom_range(128)) - 64, ly + int'($urandom_range(128)) - 64,
                     lx + int'($urandom_range(128)) - 64, ly + int'($urandom_range(128)) - 64);
      end
      7: begin
        if ($urandom_range(1)) f.fx = f.lx;
        else f.fy = f.ly;
        if ($urandom_range(1)) f.rx = f.lx;
        else f.ry = f.ly;
        if ($urandom_range(3) == 0) begin
          f.fx = f.lx;
          f.fy = f.ly;
        end
      end
      8: begin
        lx = $urandom_range(512, 15871);
        ly = $urandom_range(512, 15871);
        a  = int'($urandom_range(1000)) - 500;
        b  = int'($urandom_range(1000)) - 500;
        f  = mk_frame(lx, ly, hd, lx + a, ly + b, lx - b, ly + a);
        if ($urandom_range(1)) f.ry = f.ry + 1'b1;
      end
      default: ;
    endcase
    return f;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_frame(input aim_frame_t f, input bit typed, input aim_result_t want);
    aim_result_t model;
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    laser_x  = f.lx;
    laser_y  = f.ly;
    heading  = f.hd;
    front_x  = f.fx;
    front_y  = f.fy;
    rear_x   = f.rx;
    rear_y   = f.ry;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    model = predict_aim(f);
    pending_aims.insert(pending_aims.size(), typed ? want : model);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    aim_result_t none;
    none = '0;
    repeat (count) send_frame(random_frame(), 1'b0, none);
  endtask

  task automatic wait_drained();
    while (pending_aims.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stall_receiver(input int cycles);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready = !rx_hold && (int'($urandom_range(99)) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_results
    aim_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_aims.size() == 0) begin
        note_mismatch($sformatf("result pw=%0d err=%0d with nothing pending",
                                new_pulse_width, aim_error));
      end else begin
        want = pending_aims.pop_front();
        if (new_pulse_width !== want.pw)
          note_mismatch($sformatf("new_pulse_width %0d, want %0d", new_pulse_width, want.pw));
        if (aim_error !== want.err)
          note_mismatch($sformatf("aim_error %0d, want %0d", aim_error, want.err));
        if (servo_angle !== want.ang)
          note_mismatch($sformatf("servo_angle %0d, want %0d", servo_angle, want.ang));
        if (aimed_at_rear !== want.rear)
          note_mismatch($sformatf("aimed_at_rear %0b, want %0b", aimed_at_rear, want.rear));
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Timed out with %0d results pending", pending_aims.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    aim_result_t none;
    none = '0;
    add_row(mk_frame(0, 0, 0, 0, 0, 100, 100), 1'b1, mk_result(1500, 0, 4096, 0));
    add_row(mk_frame(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_result(1500, 0, 4096, 0));
    add_row(mk_frame(0, 0, -16384, 0, 0, 16383, 16383), 1'b1,
            mk_result(1500, 16384, 4096, 0));
    add_row(mk_frame(0, 0, 16383, 0, 0, 16383, 16383), 1'b1,
            mk_result(1500, -16383, 4096, 0));
    add_row(mk_frame(0, 0, 0, 100, 0, 16383, 16383), 1'b1, mk_result(1500, 0, 4096, 0));
    add_row(mk_frame(16383, 0, 0, 0, 0, 0, 16383), 1'b1, mk_result(1500, 8192, 4096, 0));
    add_row(mk_frame(0, 0, 0, 0, 50, 16383, 16383), 1'b1, mk_result(2000, 4096, 4096, 0));
    add_row(mk_frame(0, 50, 0, 0, 0, 16383, 16383), 1'b1, mk_result(1000, -8192, 8192, 0));
    add_row(mk_frame(0, 0, 0, 16383, 16383, 0, 0), 1'b1, mk_result(1500, 4096, 0, 1));
    add_row(mk_frame(8000, 8000, 0, 9000, 8500, 16383, 0), 1'b0, none);
    add_row(mk_frame(8000, 8000, 1000, 7000, 8500, 0, 0), 1'b0, none);
    add_row(mk_frame(8000, 8000, -1000, 7000, 7500, 16383, 16383), 1'b0, none);
    add_row(mk_frame(8000, 8000, 8192, 9000, 7500, 0, 16383), 1'b0, none);
    add_row(mk_frame(0, 8000, -8192, 16383, 8001, 0, 0), 1'b0, none);
    add_row(mk_frame(0, 8000, 0, 16383, 8001, 16383, 16383), 1'b0, none);
    add_row(mk_frame(16383, 8000, 0, 0, 7999, 0, 0), 1'b0, none);
    add_row(mk_frame(16383, 8000, 0, 0, 8001, 0, 0), 1'b0, none);
    add_row(mk_frame(5000, 5000, 2000, 5300, 5400, 4600, 4700), 1'b0, none);
    add_row(mk_frame(5000, 5000, -2000, 5300, 5400, 4600, 4701), 1'b0, none);
    add_row(mk_frame(16383, 16383, 16383, 0, 0, 16383, 0), 1'b0, none);
    add_row(mk_frame(16383, 16383, -16384, 16383, 16383, 16383, 16383), 1'b0, none);
    add_row(mk_frame(1, 1, 0, 0, 0, 2, 2), 1'b0, none);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (aim_table[i]) send_frame(aim_table[i].frame, aim_table[i].typed, aim_table[i].want);
    send_random(640);

    tx_idle_pct = 86;
    rx_idle_pct = 16;
    send_random(640);

    in_valid = 1'b0;
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      stall_receiver(400);
      send_random(20);
    join
    send_random(680);

    in_valid = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered %0d frames: reset/extreme table, three idle mixes, a long output stall",
             frames_sent);
    $display("Checked %0d results; %0d aimed at rear, %0d pulse width recenters",
             results_seen, rear_picks, pw_recenters);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
